// ===== hw/rtl/bfe_pkg.sv =====
`default_nettype none
package bfe_pkg;

    // Mode register codes
    localparam logic [3:0] MODE_ONEMAX     = 4'd0;
    localparam logic [3:0] MODE_TRAP       = 4'd1;
    localparam logic [3:0] MODE_NIAH       = 4'd2;
    localparam logic [3:0] MODE_CTRAP      = 4'd3;
    localparam logic [3:0] MODE_CNIAH      = 4'd4;
    localparam logic [3:0] MODE_CYCTRAP    = 4'd5;
    localparam logic [3:0] MODE_ALTCYC     = 4'd6;
    localparam logic [3:0] MODE_LEADONES   = 4'd7;
    localparam logic [3:0] MODE_LEADTRAPS  = 4'd8;
    localparam logic [3:0] MODE_WEAKONEMAX = 4'd9;
    localparam logic [3:0] MODE_PATTERN    = 4'd10;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_MULTIPLE  = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

    // Score accumulator: whole units, saturating
    localparam int FS_W = 14;
    localparam logic [FS_W-1:0] FS_MAX = '1;

    // Fitness in half units before and after clamping
    localparam int HW = 17;
    localparam int FIT_W = 11;
    localparam logic signed [HW-1:0] FIT_HI = 17'sd1023;
    localparam logic signed [HW-1:0] FIT_LO = -17'sd1024;

    // Per-string flags handed from the accumulator to the result stage
    typedef struct packed {
        logic       ovf;
        logic       mod3_zero;
        logic [2:0] recent;
    } end_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bfe_accum.sv =====
`default_nettype none
module bfe_accum
    import bfe_pkg::*;
#(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [3:0]           mode,
    input  wire logic                 beat,
    input  wire logic                 gene,
    input  wire logic                 last_gene,
    input  wire logic                 snap_take,
    output logic                      snap_valid,
    output logic [$clog2(MAX_LENGTH+1)-1:0] snap_n,
    output logic [$clog2(MAX_LENGTH+1)-1:0] snap_ones,
    output logic [FS_W-1:0]           snap_fsum,
    output end_flags_t                snap_flags
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    // Gain of a 4-bit trap window, negative scores dropped
    function automatic logic [2:0] trap4_gain(input logic [2:0] c);
        logic [2:0] g;
        case (c)
            3'd4:    g = 3'd4;
            3'd0:    g = 3'd3;
            3'd1:    g = 3'd2;
            3'd2:    g = 3'd1;
            default: g = 3'd0;
        endcase
        return g;
    endfunction

    // Gain of a cyclic window, trap or zero-trap
    function automatic logic [2:0] cyc_gain(input logic [2:0] c, input logic alt);
        logic [2:0] g;
        if (alt) begin
            if (c == 3'd0)      g = 3'd4;
            else if (c == 3'd4) g = 3'd3;
            else                g = c - 3'd1;
        end else begin
            g = trap4_gain(c);
        end
        return g;
    endfunction

    // Gain of a leading-trap block of length len
    function automatic logic [2:0] lead_gain(input logic [2:0] c, input logic [2:0] len);
        logic [2:0] g;
        if (c == len)       g = 3'd4;
        else if (c == 3'd0) g = 3'd3;
        else if (c == 3'd1) g = 3'd2;
        else if (c == 3'd2) g = 3'd1;
        else                g = 3'd0;
        return g;
    endfunction

    logic [CW-1:0]   bc_reg, bc_next;
    logic [CW-1:0]   ones_reg, ones_next;
    logic [FS_W-1:0] fsum_reg, fsum_next;
    logic [2:0]      wones_reg, wones_next;
    logic [1:0]      wpos_reg, wpos_next;
    logic [1:0]      mod3_reg, mod3_next;
    logic            first_reg, first_next;
    logic            lead_reg, lead_next;
    logic            chain_reg, chain_next;
    logic            parity_reg, parity_next;
    logic            ovf_reg, ovf_next;
    logic [2:0]      recent_reg, recent_next;

    logic            snap_valid_reg;
    logic [CW-1:0]   snap_n_reg;
    logic [CW-1:0]   snap_ones_reg;
    logic [FS_W-1:0] snap_fsum_reg;
    end_flags_t      snap_flags_reg;

    logic            take;
    logic [2:0]      add_a, add_b;
    logic [2:0]      wo, wv, len;
    logic            par, first_eff;
    logic [FS_W:0]   fsum_wide;

    // Fold one gene into the running string state
    always_comb begin
        bc_next     = bc_reg;
        ones_next   = ones_reg;
        wones_next  = wones_reg;
        wpos_next   = wpos_reg;
        mod3_next   = mod3_reg;
        first_next  = first_reg;
        lead_next   = lead_reg;
        chain_next  = chain_reg;
        parity_next = parity_reg;
        ovf_next    = ovf_reg;
        recent_next = recent_reg;
        add_a       = 3'd0;
        add_b       = 3'd0;
        wo          = wones_reg + {2'b00, gene};
        wv          = wo;
        len         = {1'b0, wpos_reg} + 3'd1;
        par         = parity_reg;
        first_eff   = (bc_reg == '0) ? gene : first_reg;
        take        = !ovf_reg && (bc_reg != CW'(MAX_LENGTH));

        if (!ovf_reg && !take) begin
            ovf_next = 1'b1;
        end

        if (take) begin
            first_next  = first_eff;
            ones_next   = ones_reg + CW'(gene);
            recent_next = {recent_reg[1:0], gene};
            if (mode == MODE_LEADONES && lead_reg && gene) begin
                add_a = 3'd1;
            end
            if (!gene) begin
                lead_next = 1'b0;
            end
            mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;
            bc_next   = bc_reg + CW'(1);

            if (mode == MODE_CTRAP || mode == MODE_CNIAH || mode == MODE_LEADTRAPS) begin
                // block modes: close a block at its fourth bit, or for leading traps at the last gene
                if (wpos_reg == 2'd3 || (mode == MODE_LEADTRAPS && last_gene)) begin
                    if (mode == MODE_CTRAP) begin
                        add_a = trap4_gain(wo);
                    end else if (mode == MODE_CNIAH) begin
                        add_a = (wo == 3'd4) ? 3'd1 : 3'd0;
                    end else begin
                        if (chain_reg) begin
                            add_a = lead_gain(wo, len);
                        end
                        if (wo != len) begin
                            chain_next = 1'b0;
                        end
                    end
                    wones_next = 3'd0;
                end else begin
                    wones_next = wo;
                end
                wpos_next = wpos_reg + 2'd1;
            end else if (mode == MODE_CYCTRAP || mode == MODE_ALTCYC) begin
                // cyclic modes: close the window that ends on this bit
                if (bc_reg != '0 && wpos_reg == 2'd0) begin
                    add_a = cyc_gain(wo, mode == MODE_ALTCYC && par);
                    par   = ~par;
                    wv    = {2'b00, gene};
                end
                wones_next = wv;
                wpos_next  = (wpos_reg >= 2'd2) ? 2'd0 : wpos_reg + 2'd1;
                // wrap the final window back to bit 0
                if (last_gene && mod3_next == 2'd0) begin
                    add_b = cyc_gain(wv + {2'b00, first_eff}, mode == MODE_ALTCYC && par);
                    par   = ~par;
                end
                parity_next = par;
            end else begin
                wpos_next = wpos_reg + 2'd1;
            end
        end

        // saturate the score sum
        fsum_wide = {1'b0, fsum_reg} + {{(FS_W-2){1'b0}}, add_a}
                  + {{(FS_W-2){1'b0}}, add_b};
        if (fsum_wide > {1'b0, FS_MAX}) begin
            fsum_next = FS_MAX;
        end else begin
            fsum_next = fsum_wide[FS_W-1:0];
        end
    end

    // Advance string state; clear it after the last beat
    always_ff @(posedge aclk) begin
        if (!aresetn || (beat && last_gene)) begin
            bc_reg     <= '0;
            ones_reg   <= '0;
            fsum_reg   <= '0;
            wones_reg  <= 3'd0;
            wpos_reg   <= 2'd0;
            mod3_reg   <= 2'd0;
            first_reg  <= 1'b0;
            lead_reg   <= 1'b1;
            chain_reg  <= 1'b1;
            parity_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            recent_reg <= 3'd0;
        end else if (beat) begin
            bc_reg     <= bc_next;
            ones_reg   <= ones_next;
            fsum_reg   <= fsum_next;
            wones_reg  <= wones_next;
            wpos_reg   <= wpos_next;
            mod3_reg   <= mod3_next;
            first_reg  <= first_next;
            lead_reg   <= lead_next;
            chain_reg  <= chain_next;
            parity_reg <= parity_next;
            ovf_reg    <= ovf_next;
            recent_reg <= recent_next;
        end
    end

    // Hold the finished string for the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (beat && last_gene) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_take) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat && last_gene) begin
            snap_n_reg               <= bc_next;
            snap_ones_reg            <= ones_next;
            snap_fsum_reg            <= fsum_next;
            snap_flags_reg.ovf       <= ovf_next;
            snap_flags_reg.mod3_zero <= (mod3_next == 2'd0);
            snap_flags_reg.recent    <= recent_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap_n     = snap_n_reg;
    assign snap_ones  = snap_ones_reg;
    assign snap_fsum  = snap_fsum_reg;
    assign snap_flags = snap_flags_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bfe_result.sv =====
`default_nettype none
module bfe_result
    import bfe_pkg::*;
#(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [3:0]           mode,
    input  wire logic                 snap_valid,
    input  wire logic [$clog2(MAX_LENGTH+1)-1:0] snap_n,
    input  wire logic [$clog2(MAX_LENGTH+1)-1:0] snap_ones,
    input  wire logic [FS_W-1:0]      snap_fsum,
    input  wire end_flags_t           snap_flags,
    output logic                      snap_take,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic signed [FIT_W-1:0]   m_fitness_halves,
    output logic [1:0]                m_status
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    logic                    m_valid_reg;
    logic signed [FIT_W-1:0] fit_reg, fit_next;
    logic [1:0]              status_reg, status_next;
    logic signed [HW-1:0]    ones_s, n_s, h;

    assign snap_take = snap_valid && (!m_valid_reg || m_ready);
    assign ones_s    = signed'({{(HW-CW){1'b0}}, snap_ones});
    assign n_s       = signed'({{(HW-CW){1'b0}}, snap_n});

    // Form status and fitness of the finished string
    always_comb begin
        if (snap_flags.ovf) begin
            status_next = STATUS_TOO_LONG;
        end else if ((mode == MODE_CTRAP || mode == MODE_CNIAH) && snap_n[1:0] != 2'd0) begin
            status_next = STATUS_MULTIPLE;
        end else if ((mode == MODE_CYCTRAP || mode == MODE_ALTCYC) && !snap_flags.mod3_zero) begin
            status_next = STATUS_MULTIPLE;
        end else if (mode == MODE_CYCTRAP && snap_n <= CW'(4)) begin
            status_next = STATUS_TOO_SHORT;
        end else begin
            status_next = STATUS_OK;
        end

        h = '0;
        unique case (mode) inside
            MODE_ONEMAX: h = ones_s <<< 1;
            MODE_TRAP: begin
                if (ones_s == n_s)         h = 17'sd8;
                else if (ones_s == '0)     h = 17'sd6;
                else                       h = (17'sd3 - ones_s) <<< 1;
            end
            MODE_NIAH: h = (ones_s == n_s) ? 17'sd2 : 17'sd0;
            MODE_CTRAP, MODE_CNIAH, MODE_CYCTRAP, MODE_ALTCYC,
            MODE_LEADONES, MODE_LEADTRAPS:
                h = signed'({{(HW-FS_W-1){1'b0}}, snap_fsum, 1'b0});
            MODE_WEAKONEMAX: h = (ones_s == '0) ? 17'sd3 : (ones_s <<< 1);
            MODE_PATTERN: begin
                if (snap_n == CW'(3)) begin
                    if (snap_flags.recent == 3'b111)      h = 17'sd6;
                    else if (snap_flags.recent == 3'b100) h = 17'sd4;
                    else if (snap_flags.recent == 3'b001) h = 17'sd2;
                end
            end
            default: h = '0;
        endcase

        // clamp to the output range; errors score zero
        if (status_next != STATUS_OK) begin
            fit_next = '0;
        end else if (h > FIT_HI) begin
            fit_next = FIT_HI[FIT_W-1:0];
        end else if (h < FIT_LO) begin
            fit_next = FIT_LO[FIT_W-1:0];
        end else begin
            fit_next = h[FIT_W-1:0];
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (snap_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_take) begin
            fit_reg    <= fit_next;
            status_reg <= status_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_fitness_halves = fit_reg;
    assign m_status         = status_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bitstring_fitness_evaluator_core.sv =====
`default_nettype none
// Bit-serial fitness evaluator. A chromosome enters one gene per beat on the
// s_ channel, first bit first, with s_last_gene high on its final bit; one
// result beat per chromosome leaves on the m_ channel: fitness in half units
// (signed, saturated to 11 bits) and a status (ok, length not a multiple,
// too short, too long). The scoring function is chosen by the 4-bit mode
// register, written through the cfg_ channel. The user must write it only
// while no string is in flight; the block itself does not enforce this.
// One gene is taken every cycle unless the end-of-string register is stuck
// full, so strings may follow one another without gaps; each beat updates a
// set of small counters. The result of a string passes through the
// end-of-string register and then the output register. Genes beyond
// MAX_LENGTH are dropped and flag the string as too long.
module bitstring_fitness_evaluator_core
    import bfe_pkg::*;
#(
    parameter int MAX_LENGTH = 256
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [3:0]            cfg_mode,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_gene,
    input  wire logic                  s_last_gene,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [FIT_W-1:0]    m_fitness_halves,
    output logic [1:0]                 m_status
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    logic [3:0]      mode_reg;
    logic            beat;
    logic            snap_valid;
    logic            snap_take;
    logic [CW-1:0]   snap_n;
    logic [CW-1:0]   snap_ones;
    logic [FS_W-1:0] snap_fsum;
    end_flags_t      snap_flags;

    // Mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ONEMAX;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_mode;
        end
    end

    // Accept a gene unless the end-of-string register is stuck full
    assign s_ready = !snap_valid || snap_take;
    assign beat    = s_valid && s_ready;

    bfe_accum #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .beat       (beat),
        .gene       (s_gene),
        .last_gene  (s_last_gene),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap_n     (snap_n),
        .snap_ones  (snap_ones),
        .snap_fsum  (snap_fsum),
        .snap_flags (snap_flags)
    );

    bfe_result #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_result (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .mode             (mode_reg),
        .snap_valid       (snap_valid),
        .snap_n           (snap_n),
        .snap_ones        (snap_ones),
        .snap_fsum        (snap_fsum),
        .snap_flags       (snap_flags),
        .snap_take        (snap_take),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fitness_halves (m_fitness_halves),
        .m_status         (m_status)
    );

endmodule
`default_nettype wire

// ===== verif/bitstring_fitness_evaluator_core_tb.sv =====
`default_nettype none
module bitstring_fitness_evaluator_core_tb;
    import bfe_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_GENES    = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    logic                     aclk;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [3:0]               cfg_mode = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_gene = 1'b0;
    logic                     s_last_gene = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [FIT_W-1:0]  m_fitness_halves;
    logic [1:0]               m_status;

    typedef struct packed {
        logic signed [FIT_W-1:0] fitness_halves;
        logic [1:0]              status;
    } fitness_result_t;

    // Scores predicted for chromosomes already sent, oldest first
    fitness_result_t expected_scores[$];

    // Shadow of the evaluator: mode register and per-chromosome state
    logic [3:0]  active_mode;
    logic [12:0] gene_cnt;
    logic [12:0] ones_cnt;
    logic [13:0] score_acc;
    logic [2:0]  win_ones;
    logic [1:0]  win_pos;
    logic        head_gene;
    logic        lead_alive;
    logic        chain_alive;
    logic        win_parity;
    logic        too_long;
    logic [2:0]  last3;

    // Run bookkeeping
    int          error_count = 0;
    int          genes_sent = 0;
    int          strings_sent = 0;
    int          results_seen = 0;
    logic [15:0] modes_seen = '0;
    logic        tx_gaps_on = 1'b1;
    logic        rx_stall_on = 1'b1;
    int          stall_left = 0;

    bitstring_fitness_evaluator_core #(
        .MAX_LENGTH(MAX_GENES)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_mode         (cfg_mode),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_gene           (s_gene),
        .s_last_gene      (s_last_gene),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fitness_halves (m_fitness_halves),
        .m_status         (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Fitness predictor
    // ------------------------------------------------------------------

    function automatic void clear_chromosome();
        gene_cnt    = '0;
        ones_cnt    = '0;
        score_acc   = '0;
        win_ones    = '0;
        win_pos     = '0;
        head_gene   = 1'b0;
        lead_alive  = 1'b1;
        chain_alive = 1'b1;
        win_parity  = 1'b0;
        too_long    = 1'b0;
        last3       = '0;
    endfunction

    function automatic int trap_points(input int c, input int len);
        if (c == len) return 4;
        if (c == 0) return 3;
        return 3 - c;
    endfunction

    // Add a positive score, saturating at the accumulator's top
    function automatic void add_points(input int pts);
        int t;
        if (pts > 0) begin
            t = int'(score_acc) + pts;
            score_acc = (t > 16383) ? 14'h3FFF : t[13:0];
        end
    endfunction

    // Score one cyclic window; odd windows in alternating mode use zero-trap
    function automatic void close_window(input logic [2:0] c);
        if (active_mode == MODE_ALTCYC && win_parity) begin
            if (c == 3'd0) add_points(4);
            else if (c == 3'd4) add_points(3);
            else add_points(int'(c) - 1);
        end else begin
            add_points(trap_points(int'(c), 4));
        end
        win_parity = !win_parity;
    endfunction

    function automatic void absorb_gene(input logic g, input logic is_last);
        logic [12:0] pos;
        logic [2:0]  wo;
        int          pts;
        pos = gene_cnt;
        if (pos == 0) head_gene = g;
        ones_cnt = ones_cnt + 13'(g);
        last3 = {last3[1:0], g};
        if (active_mode == MODE_LEADONES && lead_alive && g) add_points(1);
        if (!g) lead_alive = 1'b0;

        if (active_mode == MODE_CTRAP || active_mode == MODE_CNIAH ||
            active_mode == MODE_LEADTRAPS) begin
            // 4-bit blocks; leading traps also closes a short final block
            wo = win_ones + 3'(g);
            if (win_pos == 2'd3 || (active_mode == MODE_LEADTRAPS && is_last)) begin
                if (active_mode == MODE_CTRAP) begin
                    add_points(trap_points(int'(wo), 4));
                end else if (active_mode == MODE_CNIAH) begin
                    add_points((wo == 3'd4) ? 1 : 0);
                end else begin
                    pts = trap_points(int'(wo), int'(win_pos) + 1);
                    if (chain_alive) add_points(pts);
                    if (pts != 4) chain_alive = 1'b0;
                end
                win_ones = '0;
            end else begin
                win_ones = wo;
            end
            win_pos = win_pos + 2'd1;
        end else if (active_mode == MODE_CYCTRAP || active_mode == MODE_ALTCYC) begin
            // windows of 4 every 3 bits; the last one wraps to the first gene
            if (pos != 0 && win_pos == 2'd0) begin
                close_window(win_ones + 3'(g));
                win_ones = {2'b00, g};
            end else begin
                win_ones = win_ones + 3'(g);
            end
            win_pos = (win_pos >= 2'd2) ? 2'd0 : win_pos + 2'd1;
            if (is_last && ((int'(pos) + 1) % 3) == 0)
                close_window(win_ones + 3'(head_gene));
        end else begin
            win_pos = win_pos + 2'd1;
        end
        gene_cnt = pos + 13'd1;
    endfunction

    // Advance the shadow by one accepted gene beat; queue a score at the end
    function automatic void predict_gene(input logic g, input logic is_last);
        fitness_result_t r;
        int              h;
        logic [1:0]      st;
        if (!too_long) begin
            if (gene_cnt >= MAX_GENES) too_long = 1'b1;
            else absorb_gene(g, is_last);
        end
        if (is_last) begin
            st = STATUS_OK;
            h = 0;
            if (too_long)
                st = STATUS_TOO_LONG;
            else if ((active_mode == MODE_CTRAP || active_mode == MODE_CNIAH) &&
                     gene_cnt[1:0] != 2'd0)
                st = STATUS_MULTIPLE;
            else if ((active_mode == MODE_CYCTRAP || active_mode == MODE_ALTCYC) &&
                     (int'(gene_cnt) % 3) != 0)
                st = STATUS_MULTIPLE;
            else if (active_mode == MODE_CYCTRAP && gene_cnt <= 4)
                st = STATUS_TOO_SHORT;

            if (st == STATUS_OK) begin
                case (active_mode)
                    MODE_ONEMAX: h = 2 * int'(ones_cnt);
                    MODE_TRAP: h = 2 * trap_points(int'(ones_cnt), int'(gene_cnt));
                    MODE_NIAH: h = (ones_cnt == gene_cnt) ? 2 : 0;
                    MODE_CTRAP, MODE_CNIAH, MODE_CYCTRAP, MODE_ALTCYC,
                    MODE_LEADONES, MODE_LEADTRAPS: h = 2 * int'(score_acc);
                    MODE_WEAKONEMAX: h = (ones_cnt == 0) ? 3 : 2 * int'(ones_cnt);
                    MODE_PATTERN: begin
                        if (gene_cnt == 3) begin
                            case (last3)
                                3'b111: h = 6;
                                3'b100: h = 4;
                                3'b001: h = 2;
                                default: h = 0;
                            endcase
                        end
                    end
                    default: h = 0;
                endcase
            end
            if (h > 1023) h = 1023;
            if (h < -1024) h = -1024;
            r.fitness_halves = h[FIT_W-1:0];
            r.status = st;
            expected_scores.insert(expected_scores.size(), r);
            clear_chromosome();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    task automatic send_gene(input logic g, input logic is_last);
        int gap;
        s_valid <= 1'b1;
        s_gene <= g;
        s_last_gene <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_gene(g, is_last);
        genes_sent++;
        if (is_last) strings_sent++;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Send len bits of pattern, most significant first
    task automatic send_bits(input logic [15:0] pattern, input int len);
        for (int i = len - 1; i >= 0; i--) send_gene(pattern[i], i == 0);
    endtask

    task automatic send_random_chromosome(input int len, input int ones_pct);
        for (int i = 0; i < len; i++)
            send_gene($urandom_range(0, 99) < ones_pct, i == len - 1);
    endtask

    // Drop valid and hold until every queued score has come back
    task automatic drain_results();
        if (s_valid) s_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [3:0] m);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_mode <= m;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        active_mode = m;
        modes_seen[m] = 1'b1;
    endtask

    // Well-formed lengths for the mode most of the time, odd ones otherwise
    function automatic int pick_length(input logic [3:0] m);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return $urandom_range(1, 20);
        case (m)
            MODE_CTRAP, MODE_CNIAH: return 4 * $urandom_range(1, 4);
            MODE_LEADTRAPS: return $urandom_range(1, 13);
            MODE_CYCTRAP: return 3 * $urandom_range(2, 5);
            MODE_ALTCYC: return 3 * $urandom_range(1, 5);
            MODE_PATTERN: return 3;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic int pick_ones_pct();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 20;
            2: return 50;
            3: return 85;
            default: return 100;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result channel: pace ready and check each beat
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_monitor
        fitness_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_scores.size() == 0) begin
                flag_error($sformatf("unexpected result fitness=%0d status=%0d",
                                     m_fitness_halves, m_status));
            end else begin
                want = expected_scores.pop_front();
                if (m_fitness_halves !== want.fitness_halves || m_status !== want.status)
                    flag_error($sformatf("fitness exp %0d got %0d, status exp %0d got %0d",
                                         want.fitness_halves, m_fitness_halves,
                                         want.status, m_status));
            end
        end
        // stall ready in random bursts while stalls are enabled
        if (!rx_stall_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            m_ready <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One short chromosome per mode, including the length error cases
    task automatic test_directed_modes();
        // onemax from reset, all-zero and all-one strings
        send_bits(16'b1, 1);
        send_bits(16'b0, 1);
        write_mode(MODE_TRAP);
        send_bits(16'b10, 2);
        write_mode(MODE_NIAH);
        send_bits(16'b11, 2);
        write_mode(MODE_CTRAP);
        send_bits(16'b1111, 4);
        // length not a multiple of four
        write_mode(MODE_CNIAH);
        send_bits(16'b111, 3);
        // cyclic trap needs more than four bits
        write_mode(MODE_CYCTRAP);
        send_bits(16'b111, 3);
        write_mode(MODE_ALTCYC);
        send_bits(16'b01, 2);
        write_mode(MODE_LEADONES);
        send_bits(16'b110, 3);
        // short final block still scores while the chain holds
        write_mode(MODE_LEADTRAPS);
        send_bits(16'b11110, 5);
        // no ones scores one and a half
        write_mode(MODE_WEAKONEMAX);
        send_bits(16'b00, 2);
        write_mode(MODE_PATTERN);
        send_bits(16'b100, 3);
        // unknown mode scores zero
        write_mode(4'hF);
        send_bits(16'b1, 1);
    endtask

    // A full-length string and one a gene past the length limit
    task automatic test_length_limit();
        write_mode(MODE_ONEMAX);
        send_random_chromosome(MAX_GENES, 100);
        write_mode(MODE_CTRAP);
        send_random_chromosome(MAX_GENES + 1, 50);
    endtask

    // Phases of random chromosomes, one mode per phase
    task automatic test_random_modes();
        logic [3:0] m;
        int         budget;
        int         start;
        for (int phase = 0; phase < 15; phase++) begin
            if (phase <= 10) m = phase[3:0];
            else if (phase == 11) m = 4'd11;
            else if (phase == 12) m = 4'hF;
            else m = $urandom_range(0, 10);
            write_mode(m);
            // every fourth phase runs back to back with no idling
            tx_gaps_on = (phase % 4) != 3;
            rx_stall_on = (phase % 4) != 3;
            budget = (m > MODE_PATTERN) ? 4 : 12;
            start = genes_sent;
            while (genes_sent - start < budget) begin
                send_random_chromosome(pick_length(m), pick_ones_pct());
                // midway through phase five, hold the sender until all scores are back
                if (phase == 5 && genes_sent - start >= budget / 2 &&
                    genes_sent - start < budget / 2 + 12)
                    drain_results();
            end
        end
        tx_gaps_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    initial begin
        active_mode = MODE_ONEMAX;
        clear_chromosome();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        modes_seen[MODE_ONEMAX] = 1'b1;
        test_directed_modes();
        test_length_limit();
        test_random_modes();
        drain_results();
        $display("Sent %0d chromosomes (%0d gene beats), checked %0d scores.",
                 strings_sent, genes_sent, results_seen);
        $display("Modes exercised (bit per mode): %b", modes_seen);
        if (error_count == 0 && expected_scores.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
